// File: hw/rtl/cbo_pkg.sv
// Shared types and constants for the cell bin overlap block.
`default_nettype none
package cbo_pkg;

	typedef enum logic [2:0] {
		CFG_X_ORIGIN   = 3'd0,
		CFG_Y_ORIGIN   = 3'd1,
		CFG_X_BIN_SIZE = 3'd2,
		CFG_Y_BIN_SIZE = 3'd3,
		CFG_X_INV_SIZE = 3'd4,
		CFG_Y_INV_SIZE = 3'd5,
		CFG_SCALE      = 3'd6
	} cfg_idx_t;

	localparam int NUM_OVERLAP_FIELDS = 8;
	localparam int PIPE_DEPTH = 10;

	localparam logic signed [31:0] RST_ORIGIN   = 32'sd0;
	localparam logic [30:0]        RST_BIN_SIZE = 31'd256000;
	localparam logic [30:0]        RST_INV_SIZE = 31'd16777;
	localparam logic [31:0]        RST_SCALE    = 32'd65536;

	localparam logic [15:0] INDEX_MAX   = 16'hFFFF;
	localparam logic [30:0] OVERLAP_MAX = 31'h7FFF_FFFF;
	localparam logic [63:0] ROUND_HALF  = 64'h8000;

endpackage
`default_nettype wire

// File: hw/rtl/cell_bin_overlap_top.sv
// Top level of the cell bin overlap block: a ten stage pipeline from cell to overlaps.
`default_nettype none
// One cell word is taken in every clock cycle while busy is low, and busy never rises, so
// cells can stream back to back. Each result word appears on the result ports for one cycle,
// marked by done; results leave in the order the cells came in. Each cell passes through
// the register stages of the datapath in this order: the offset subtract, the reciprocal
// multiply, the bin edge multiply, the edge add, the two correction steps, the per-bin edge
// adds, the overlap clip, the scale multiply and the rounding. The configuration registers
// feed the pipeline directly and must be written only while no cell is in flight.
module cell_bin_overlap_top #(
	parameter int MAX_OVERLAP_BINS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        func,
	input  wire logic [31:0] position,
	input  wire logic [30:0] extent,
	output logic             done,
	output logic [15:0]      bin_index,
	output logic [30:0]      overlap_0,
	output logic [30:0]      overlap_1,
	output logic [30:0]      overlap_2,
	output logic [30:0]      overlap_3,
	output logic [30:0]      overlap_4,
	output logic [30:0]      overlap_5,
	output logic [30:0]      overlap_6,
	output logic [30:0]      overlap_7,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic signed [31:0] x_origin_q, y_origin_q;
	logic [30:0] x_bin_size_q, y_bin_size_q, x_inv_q, y_inv_q;
	logic [31:0] scale_q;

	logic [cbo_pkg::PIPE_DEPTH-1:0] vld_q;

	logic                  func_s1, func_s2, func_s3, func_s4, func_s5, func_s6;
	logic signed [31:0]    pos_s1, pos_s2, pos_s3, pos_s4, pos_s5, pos_s6;
	logic [30:0]           ext_s1, ext_s2, ext_s3, ext_s4, ext_s5;
	logic signed [32:0]    diff_s1;
	logic signed [64:0]    prod_s2;
	logic [30:0]           idx_s3, idx_s4;
	logic [61:0]           ibsz_s3;
	logic signed [63:0]    edge_s4, edge_s5, edge_s6;
	logic signed [31:0]    idx_s5;
	logic [31:0]           idx_s6;
	logic signed [63:0]    cell_hi_s6, cell_hi_s7;
	logic signed [63:0]    pos_s7;
	logic [15:0]           bidx_s7, bidx_s8, bidx_s9, bidx_s10;

	logic signed [31:0]    org_in, org_s3, org_s5;
	logic [30:0]           inv_s1, bsz_s2, bsz_s4, bsz_s5, bsz_s6;
	logic [30:0]           idx0_c;
	logic                  dn_c, up_c;
	logic signed [32:0]    idx2_c;
	logic signed [63:0]    pos64_s4, pos64_s5, up_edge_c;

	logic [30:0] lane_res [cbo_pkg::NUM_OVERLAP_FIELDS];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q   <= cbo_pkg::RST_ORIGIN;
			y_origin_q   <= cbo_pkg::RST_ORIGIN;
			x_bin_size_q <= cbo_pkg::RST_BIN_SIZE;
			y_bin_size_q <= cbo_pkg::RST_BIN_SIZE;
			x_inv_q      <= cbo_pkg::RST_INV_SIZE;
			y_inv_q      <= cbo_pkg::RST_INV_SIZE;
			scale_q      <= cbo_pkg::RST_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbo_pkg::CFG_X_ORIGIN:   x_origin_q   <= $signed(cfg_data);
				cbo_pkg::CFG_Y_ORIGIN:   y_origin_q   <= $signed(cfg_data);
				cbo_pkg::CFG_X_BIN_SIZE: x_bin_size_q <= cfg_data[30:0];
				cbo_pkg::CFG_Y_BIN_SIZE: y_bin_size_q <= cfg_data[30:0];
				cbo_pkg::CFG_X_INV_SIZE: x_inv_q      <= cfg_data[30:0];
				cbo_pkg::CFG_Y_INV_SIZE: y_inv_q      <= cfg_data[30:0];
				cbo_pkg::CFG_SCALE:      scale_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[cbo_pkg::PIPE_DEPTH-2:0], start && !busy};
		end
	end

	assign done = vld_q[cbo_pkg::PIPE_DEPTH-1];

	always_comb begin
		org_in    = func    ? y_origin_q   : x_origin_q;
		inv_s1    = func_s1 ? y_inv_q      : x_inv_q;
		bsz_s2    = func_s2 ? y_bin_size_q : x_bin_size_q;
		org_s3    = func_s3 ? y_origin_q   : x_origin_q;
		bsz_s4    = func_s4 ? y_bin_size_q : x_bin_size_q;
		bsz_s5    = func_s5 ? y_bin_size_q : x_bin_size_q;
		org_s5    = func_s5 ? y_origin_q   : x_origin_q;
		bsz_s6    = func_s6 ? y_bin_size_q : x_bin_size_q;
		idx0_c    = prod_s2[64] ? '0 : prod_s2[62:32];
		pos64_s4  = 64'(pos_s4);
		pos64_s5  = 64'(pos_s5);
		dn_c      = edge_s4 > pos64_s4;
		up_edge_c = edge_s5 + $signed({33'd0, bsz_s5});
		up_c      = up_edge_c <= pos64_s5;
		idx2_c    = 33'(idx_s5) + $signed({32'd0, up_c});
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		pos_s1  <= $signed(position);
		ext_s1  <= extent;
		diff_s1 <= 33'(signed'(position)) - 33'(org_in);

		func_s2 <= func_s1;
		pos_s2  <= pos_s1;
		ext_s2  <= ext_s1;
		prod_s2 <= 65'(diff_s1) * $signed({34'd0, inv_s1});

		func_s3 <= func_s2;
		pos_s3  <= pos_s2;
		ext_s3  <= ext_s2;
		idx_s3  <= idx0_c;
		ibsz_s3 <= idx0_c * bsz_s2;

		func_s4 <= func_s3;
		pos_s4  <= pos_s3;
		ext_s4  <= ext_s3;
		idx_s4  <= idx_s3;
		edge_s4 <= 64'(org_s3) + $signed({2'b00, ibsz_s3});

		func_s5 <= func_s4;
		pos_s5  <= pos_s4;
		ext_s5  <= ext_s4;
		edge_s5 <= dn_c ? edge_s4 - $signed({33'd0, bsz_s4}) : edge_s4;
		idx_s5  <= $signed({1'b0, idx_s4}) - $signed({31'd0, dn_c});

		func_s6    <= func_s5;
		pos_s6     <= pos_s5;
		cell_hi_s6 <= pos64_s5 + $signed({33'd0, ext_s5});
		if (idx2_c[32]) begin
			idx_s6  <= '0;
			edge_s6 <= 64'(org_s5);
		end else begin
			idx_s6  <= idx2_c[31:0];
			edge_s6 <= up_c ? up_edge_c : edge_s5;
		end

		pos_s7     <= 64'(pos_s6);
		cell_hi_s7 <= cell_hi_s6;
		bidx_s7    <= (idx_s6 > 32'(cbo_pkg::INDEX_MAX)) ? cbo_pkg::INDEX_MAX : idx_s6[15:0];
		bidx_s8    <= bidx_s7;
		bidx_s9    <= bidx_s8;
		bidx_s10   <= bidx_s9;
	end

	for (genvar j = 0; j < cbo_pkg::NUM_OVERLAP_FIELDS; j++) begin : g_lane
		if (j < MAX_OVERLAP_BINS) begin : g_on
			localparam logic [63:0] LO_MUL = 64'(j);
			localparam logic [63:0] HI_MUL = 64'(j + 1);
			logic signed [63:0] blo_s7, bhi_s7;
			logic signed [63:0] lo_c, hi_c, ov_c;
			logic [30:0]        ov_s8;
			logic [62:0]        p_s9;
			logic [63:0]        rnd_c;
			logic [30:0]        res_s10;

			always_comb begin
				lo_c  = (blo_s7 > pos_s7) ? blo_s7 : pos_s7;
				hi_c  = (bhi_s7 < cell_hi_s7) ? bhi_s7 : cell_hi_s7;
				ov_c  = hi_c - lo_c;
				rnd_c = (64'(p_s9) + cbo_pkg::ROUND_HALF) >> 16;
			end

			always_ff @(posedge clk) begin
				blo_s7  <= edge_s6 + $signed(64'(bsz_s6) * LO_MUL);
				bhi_s7  <= edge_s6 + $signed(64'(bsz_s6) * HI_MUL);
				ov_s8   <= ov_c[63] ? '0 : ov_c[30:0];
				p_s9    <= ov_s8 * scale_q;
				res_s10 <= (rnd_c > 64'(cbo_pkg::OVERLAP_MAX)) ? cbo_pkg::OVERLAP_MAX
				                                               : rnd_c[30:0];
			end

			assign lane_res[j] = res_s10;
		end else begin : g_off
			assign lane_res[j] = '0;
		end
	end

	assign bin_index = bidx_s10;
	assign overlap_0 = lane_res[0];
	assign overlap_1 = lane_res[1];
	assign overlap_2 = lane_res[2];
	assign overlap_3 = lane_res[3];
	assign overlap_4 = lane_res[4];
	assign overlap_5 = lane_res[5];
	assign overlap_6 = lane_res[6];
	assign overlap_7 = lane_res[7];

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the cell bin overlap block: predicted bin index and overlaps against the result ports.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int      BINS        = 8;
	localparam int      CYCLE_LIMIT = 200000;
	localparam int      PHASES      = 12;
	localparam int      PHASE_CELLS = 140;
	localparam longint  MAX31       = 64'sd2147483647;
	localparam longint  MIN32       = -64'sd2147483648;
	localparam longint  RB          = longint'(cbo_pkg::RST_BIN_SIZE);
	localparam logic [2:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic [15:0]        index;
		logic [7:0][30:0]   ov;
	} bin_word_t;

	class overlap_ledger;
		logic signed [31:0] origin [2];
		logic [30:0]        bin_size [2];
		logic [30:0]        inv_size [2];
		logic [31:0]        scale;
		bin_word_t          awaited [$];
		int                 errors;

		function new();
			origin   = '{cbo_pkg::RST_ORIGIN, cbo_pkg::RST_ORIGIN};
			bin_size = '{cbo_pkg::RST_BIN_SIZE, cbo_pkg::RST_BIN_SIZE};
			inv_size = '{cbo_pkg::RST_INV_SIZE, cbo_pkg::RST_INV_SIZE};
			scale    = cbo_pkg::RST_SCALE;
			errors   = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				cbo_pkg::CFG_X_ORIGIN:   origin[0] = data;
				cbo_pkg::CFG_Y_ORIGIN:   origin[1] = data;
				cbo_pkg::CFG_X_BIN_SIZE: bin_size[0] = data[30:0];
				cbo_pkg::CFG_Y_BIN_SIZE: bin_size[1] = data[30:0];
				cbo_pkg::CFG_X_INV_SIZE: inv_size[0] = data[30:0];
				cbo_pkg::CFG_Y_INV_SIZE: inv_size[1] = data[30:0];
				cbo_pkg::CFG_SCALE:      scale = data;
				default: ;
			endcase
		endfunction

		function void note_cell(logic f, logic [31:0] pos, logic [30:0] ext);
			longint    p, e, org, bsz, inv, prod, idx, cell_hi, blo, bhi, lo, hi, ov;
			logic [63:0] sc;
			bin_word_t w;
			p   = longint'($signed(pos));
			e   = longint'(ext);
			org = longint'(origin[f]);
			bsz = longint'(bin_size[f]);
			inv = longint'(inv_size[f]);
			prod = (p - org) * inv;
			idx = (prod < 0) ? 0 : (prod >>> 32);
			if (org + idx * bsz > p)
				idx = idx - 1;
			if (org + (idx + 1) * bsz <= p)
				idx = idx + 1;
			if (idx < 0)
				idx = 0;
			w.index = (idx > 65535) ? cbo_pkg::INDEX_MAX : idx[15:0];
			cell_hi = p + e;
			for (int j = 0; j < cbo_pkg::NUM_OVERLAP_FIELDS; j++) begin
				w.ov[j] = '0;
				if (j < BINS) begin
					blo = org + (idx + j) * bsz;
					bhi = blo + bsz;
					lo = (blo > p) ? blo : p;
					hi = (bhi < cell_hi) ? bhi : cell_hi;
					ov = (hi > lo) ? hi - lo : 0;
					sc = 64'(ov) * scale;
					sc = (sc + cbo_pkg::ROUND_HALF) >> 16;
					w.ov[j] = (sc > cbo_pkg::OVERLAP_MAX) ? cbo_pkg::OVERLAP_MAX : sc[30:0];
				end
			end
			awaited.push_back(w);
		endfunction

		function void check_result(bin_word_t got);
			bin_word_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result word with no cell pending, bin_index %0d", $time,
					got.index);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.index !== want.index) begin
				$display("%0t: bin_index expected %0d, got %0d", $time, want.index,
					got.index);
				errors++;
			end
			for (int j = 0; j < cbo_pkg::NUM_OVERLAP_FIELDS; j++) begin
				if (got.ov[j] !== want.ov[j]) begin
					$display("%0t: overlap_%0d expected %0d, got %0d", $time, j,
						want.ov[j], got.ov[j]);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        func = 1'b0;
	logic [31:0] position = '0;
	logic [30:0] extent = '0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        busy, done, cfg_ready;
	logic [15:0] bin_index;
	logic [30:0] overlap_0, overlap_1, overlap_2, overlap_3;
	logic [30:0] overlap_4, overlap_5, overlap_6, overlap_7;
	bin_word_t   seen;
	int          cycle_count = 0;

	overlap_ledger ledger = new();

	cell_bin_overlap_top #(.MAX_OVERLAP_BINS(BINS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.position(position), .extent(extent), .done(done), .bin_index(bin_index),
		.overlap_0(overlap_0), .overlap_1(overlap_1), .overlap_2(overlap_2),
		.overlap_3(overlap_3), .overlap_4(overlap_4), .overlap_5(overlap_5),
		.overlap_6(overlap_6), .overlap_7(overlap_7), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	assign seen = {bin_index, overlap_7, overlap_6, overlap_5, overlap_4,
		overlap_3, overlap_2, overlap_1, overlap_0};

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(seen);
			if (start && !busy)
				ledger.note_cell(func, position, extent);
			if (cfg_valid && cfg_ready)
				ledger.write_reg(cfg_index, cfg_data);
		end
	end

	task automatic send_cell(input logic f, input logic [31:0] p, input logic [30:0] e,
		input bit idle_ok);
		@(negedge clk);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			func <= 1'($urandom_range(0, 1));
			position <= $urandom;
			extent <= 31'($urandom);
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start <= 1'b1;
		func <= f;
		position <= p;
		extent <= e;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.awaited.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input int phase);
		logic [31:0] val [7];
		longint      b, inv;
		wait_idle();
		case (phase)
			0: val = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF,
				32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
			1: val = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd16, 32'h7FFF_FFFF,
				32'h1000_0000, 32'd2, 32'd0};
			2: val = '{32'd0, 32'd0, 32'h4000_0000, 32'd65536,
				32'd4, 32'd65536, 32'hFFFF_FFFF};
			default: begin
				for (int a = 0; a < 2; a++) begin
					val[a] = $urandom_range(0, 1) ? $urandom :
						32'($urandom_range(0, 2 ** 24) - 2 ** 23);
					b = longint'($urandom >> $urandom_range(1, 28));
					if (b == 0)
						b = 1;
					if ($urandom_range(0, 4) == 0) begin
						inv = longint'($urandom >> 1);
					end else begin
						inv = 64'sh1_0000_0000 / b + $urandom_range(0, 4) - 2;
						if (inv < 0)
							inv = 0;
						if (inv > MAX31)
							inv = MAX31;
					end
					val[2 + a] = 32'(b);
					val[4 + a] = 32'(inv);
				end
				case ($urandom_range(0, 2))
					0: val[6] = cbo_pkg::RST_SCALE;
					1: val[6] = $urandom;
					default: val[6] = $urandom_range(0, 2 ** 20);
				endcase
			end
		endcase
		for (int i = 2; i < 6; i++)
			val[i][31] = 1'($urandom_range(0, 1));
		write_reg(CFG_SPARE, $urandom);
		for (int i = 0; i < 7; i++)
			write_reg(cbo_pkg::cfg_idx_t'(i), val[i]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic make_cell(output logic f, output logic [31:0] p, output logic [30:0] e);
		longint org, b, pos_l, ext_l;
		f = 1'($urandom_range(0, 1));
		org = longint'(ledger.origin[f]);
		b = longint'(ledger.bin_size[f]);
		if ($urandom_range(0, 9) < 3) begin
			p = $urandom;
			e = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 2 ** 20));
		end else begin
			pos_l = org + (longint'($urandom_range(0, 26)) - 2) * b;
			case ($urandom_range(0, 3))
				0: ;
				1: pos_l = pos_l + b - 1;
				2: pos_l = pos_l - 1;
				default: pos_l = pos_l + longint'($urandom) % b;
			endcase
			if (pos_l < MIN32 || pos_l > MAX31)
				pos_l = longint'($signed($urandom));
			case ($urandom_range(0, 3))
				0: ext_l = 0;
				1: ext_l = longint'($urandom_range(1, 9)) * b;
				2: ext_l = longint'($urandom) % (9 * b + 1);
				default: ext_l = longint'($urandom >> 1);
			endcase
			if (ext_l > MAX31)
				ext_l = MAX31;
			p = pos_l[31:0];
			e = ext_l[30:0];
		end
	endtask

	initial begin
		logic        f;
		logic [31:0] p;
		logic [30:0] e;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_cell(1'b0, 32'd0, 31'd0, 1'b1);
		send_cell(1'b1, 32'd0, 31'(RB), 1'b1);
		send_cell(1'b0, 32'(RB - 1), 31'd2, 1'b1);
		send_cell(1'b1, 32'(RB), 31'(8 * RB), 1'b1);
		send_cell(1'b0, 32'hFFFF_FFFF, 31'(3 * RB), 1'b1);
		send_cell(1'b1, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
		send_cell(1'b0, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
		send_cell(1'b1, 32'h8000_0000, 31'd0, 1'b1);
		send_cell(1'b0, 32'(1000 * RB + RB / 2), 31'(RB), 1'b1);
		send_cell(1'b1, 32'd0, 31'h7FFF_FFFF, 1'b1);
		send_cell(1'b0, 32'(5 * RB), 31'd0, 1'b1);
		send_cell(1'b1, 32'(3 * RB - 1), 31'd1, 1'b1);
		send_cell(1'b0, 32'd1, 31'(9 * RB), 1'b1);
		send_cell(1'b1, 32'h7FFF_FFFF, 31'd0, 1'b1);
		send_cell(1'b0, 32'(-RB), 31'(2 * RB), 1'b1);
		send_cell(1'b1, 32'(7 * RB), 31'(RB / 3), 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			configure(ph);
			for (int n = 0; n < PHASE_CELLS; n++) begin
				make_cell(f, p, e);
				send_cell(f, p, e, ph < PHASES - 1);
			end
		end

		wait_idle();
		repeat (cbo_pkg::PIPE_DEPTH + 4) @(posedge clk);
		if (ledger.errors == 0 && ledger.awaited.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
